/* sv/smx_pkg.sv */
// Shared types, codes, lookup tables and helpers of the sensor matrix scanner.
`timescale 1ns / 1ps

package smx_pkg;

    localparam int          ROWS           = 4;
    localparam int          COLS           = 4;
    localparam int          SQUARES        = ROWS * COLS;
    localparam logic [15:0] INTERVAL_RESET = 16'd10;
    localparam logic [2:0]  ROW_NONE       = 3'd4;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CAL   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CHANGE = 2'd1;
    localparam logic [1:0] KIND_OCC    = 2'd2;
    localparam logic [1:0] KIND_CAL    = 2'd3;

    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_LED      = 1'b1;

    localparam logic [3:0] LED_LUT [0:15] = '{
        4'd0, 4'd7, 4'd8, 4'd15, 4'd1, 4'd6, 4'd9, 4'd14,
        4'd2, 4'd5, 4'd10, 4'd13, 4'd3, 4'd4, 4'd11, 4'd12
    };

    // Raw square to displayed square, one table per nonzero rotation
    localparam logic [3:0] MAP_ROT1 [0:15] = '{
        4'd3, 4'd7, 4'd11, 4'd15, 4'd2, 4'd6, 4'd10, 4'd14,
        4'd1, 4'd5, 4'd9, 4'd13, 4'd0, 4'd4, 4'd8, 4'd12
    };
    localparam logic [3:0] MAP_ROT2 [0:15] = '{
        4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
    };
    localparam logic [3:0] MAP_ROT3 [0:15] = '{
        4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
        4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3
    };

    typedef enum logic [1:0] {
        MODE_EMPTY,
        MODE_EVENTS,
        MODE_QUERY
    } t_mode;

    // One classified item handed from the front end to the back end
    typedef struct packed {
        t_mode       mode;
        logic [15:0] mask;
        logic [3:0]  act;
        logic [1:0]  rot_old;
        logic [1:0]  rot_new;
        logic        cal_valid;
        logic [1:0]  cal_col;
        logic        led_en;
        logic [2:0]  row_drive;
    } t_job;

    function automatic logic [3:0] map_square(input logic [3:0] raw, input logic [1:0] rot);
        logic [3:0] sq;
        case (rot)
            2'd1:    sq = MAP_ROT1[raw];
            2'd2:    sq = MAP_ROT2[raw];
            2'd3:    sq = MAP_ROT3[raw];
            default: sq = raw;
        endcase
        return sq;
    endfunction

    function automatic logic [3:0] low_bit(input logic [15:0] bits);
        logic [3:0] idx;
        idx = 4'd0;
        for (int k = SQUARES - 1; k >= 0; k--) begin
            if (bits[k]) idx = 4'(k);
        end
        return idx;
    endfunction

endpackage

/* sv/smx_front.sv */
// Front end: takes items and config writes, keeps scan state, classifies items into jobs.
`timescale 1ns / 1ps

module smx_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_ms,
    input  logic [3:0]         i_column_levels,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_q_full,
    output logic               o_push,
    output smx_pkg::t_job      o_job
);

    logic [15:0] r_interval;
    logic        r_led_en;
    logic [31:0] r_due,       n_due;
    logic [2:0]  r_phase,     n_phase;
    logic [3:0]  r_row_bits [0:3];
    logic [3:0]  n_row_bits [0:3];
    logic [1:0]  r_rot,       n_rot;
    logic        r_calib,     n_calib;
    logic [2:0]  r_driven,    n_driven;

    logic        accept;
    logic [1:0]  row;
    logic [3:0]  act;
    logic [3:0]  diff;
    logic [3:0]  rise;
    logic [3:0]  cal_idx;
    smx_pkg::t_job job;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept;
    assign o_job       = job;

    always_comb begin
        n_due      = r_due;
        n_phase    = r_phase;
        n_row_bits = r_row_bits;
        n_rot      = r_rot;
        n_calib    = r_calib;
        n_driven   = r_driven;
        row        = 2'd0;
        act        = ~i_column_levels;
        diff       = 4'd0;
        rise       = 4'd0;
        cal_idx    = 4'd0;

        job           = '0;
        job.mode      = smx_pkg::MODE_EMPTY;
        job.rot_old   = r_rot;
        job.led_en    = r_led_en;

        case (i_op)
            smx_pkg::OP_TICK: begin
                if (i_now_ms > r_due) begin
                    n_phase = r_phase + 3'd1;
                    n_due   = i_now_ms + {16'd0, r_interval};
                    row     = n_phase[2:1];
                    if (n_phase[0]) begin
                        n_driven = {1'b0, row};
                    end else begin
                        diff            = act ^ r_row_bits[row];
                        rise            = diff & act;
                        n_row_bits[row] = act;
                        job.act         = act;
                        if (diff != 4'd0) begin
                            job.mode = smx_pkg::MODE_EVENTS;
                            job.mask = {12'd0, diff} << {row, 2'b00};
                        end
                        // first rising bit while calibrating picks the corner
                        if (r_calib && rise != 4'd0) begin
                            cal_idx       = smx_pkg::low_bit({12'd0, rise});
                            job.cal_valid = 1'b1;
                            job.cal_col   = cal_idx[1:0];
                            n_calib       = 1'b0;
                            if (row == 2'd0 && cal_idx[1:0] == 2'd0) n_rot = 2'd0;
                            if (row == 2'd0 && cal_idx[1:0] == 2'd3) n_rot = 2'd3;
                            if (row == 2'd3 && cal_idx[1:0] == 2'd0) n_rot = 2'd1;
                            if (row == 2'd3 && cal_idx[1:0] == 2'd3) n_rot = 2'd2;
                        end
                    end
                end
            end
            smx_pkg::OP_CAL: begin
                n_calib = 1'b1;
            end
            smx_pkg::OP_QUERY: begin
                job.mask = {r_row_bits[3], r_row_bits[2], r_row_bits[1], r_row_bits[0]};
                if (job.mask != 16'd0) job.mode = smx_pkg::MODE_QUERY;
            end
            default: begin
            end
        endcase

        job.rot_new   = n_rot;
        job.row_drive = n_driven;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= smx_pkg::INTERVAL_RESET;
            r_led_en   <= 1'b1;
            r_due      <= 32'd0;
            r_phase    <= 3'd7;
            r_row_bits <= '{default: 4'd0};
            r_rot      <= 2'd0;
            r_calib    <= 1'b0;
            r_driven   <= smx_pkg::ROW_NONE;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    smx_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                    smx_pkg::CFG_LED:      r_led_en   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_due      <= n_due;
                r_phase    <= n_phase;
                r_row_bits <= n_row_bits;
                r_rot      <= n_rot;
                r_calib    <= n_calib;
                r_driven   <= n_driven;
            end
        end
    end

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_driven[2] |-> r_driven[1:0] == 2'd0)
        else $error("driven row out of range");

    a_cal_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == smx_pkg::OP_CAL |=> r_calib)
        else $error("calibration start not taken");

    a_rows_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> r_row_bits[0] == $past(r_row_bits[0])
                 && r_row_bits[3] == $past(r_row_bits[3]))
        else $error("row bits changed without an item");

endmodule

/* sv/smx_queue.sv */
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module smx_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smx_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output smx_pkg::t_job o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    smx_pkg::t_job    r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/smx_back.sv */
// Back end: walks a job's square mask and emits one result beat per cycle while its output is not stalled.
`timescale 1ns / 1ps

module smx_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  smx_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_kind,
    output logic [3:0]    o_square,
    output logic          o_rising,
    output logic          o_led_valid,
    output logic [3:0]    o_led_square,
    output logic [2:0]    o_row_drive,
    output logic [1:0]    o_rotation_now,
    output logic          o_last
);

    logic          r_busy;
    smx_pkg::t_job r_job;
    logic [15:0]   r_mask;
    logic          r_out_valid;
    logic [1:0]    r_kind;
    logic [3:0]    r_square;
    logic          r_rising;
    logic          r_led_valid;
    logic [3:0]    r_led_square;
    logic [2:0]    r_row_drive;
    logic [1:0]    r_rot_now;
    logic          r_last;

    logic          emit;
    logic [3:0]    idx;
    logic [1:0]    col;
    logic [15:0]   rest;
    logic          hit;
    logic          is_cal;
    logic [1:0]    rot;
    logic [1:0]    e_kind;
    logic [3:0]    e_square;
    logic          e_rising;
    logic          e_led_valid;
    logic [3:0]    e_led_square;
    logic          e_last;

    assign o_pop = !r_busy && i_q_valid;
    assign emit  = r_busy && (!r_out_valid || i_out_ready);

    always_comb begin
        idx          = smx_pkg::low_bit(r_mask);
        col          = idx[1:0];
        rest         = r_mask & ~(16'd1 << idx);
        hit          = r_job.act[col];
        is_cal       = r_job.cal_valid && col == r_job.cal_col;
        // squares from the calibration edge on see the new rotation
        rot          = (r_job.cal_valid && col >= r_job.cal_col) ? r_job.rot_new
                                                                   : r_job.rot_old;
        e_kind       = smx_pkg::KIND_NONE;
        e_square     = 4'd0;
        e_rising     = 1'b0;
        e_led_valid  = 1'b0;
        e_led_square = 4'd0;
        e_last       = rest == 16'd0;
        case (r_job.mode)
            smx_pkg::MODE_EVENTS: begin
                e_square = smx_pkg::map_square(idx, rot);
                if (is_cal) begin
                    e_kind   = smx_pkg::KIND_CAL;
                    e_rising = 1'b1;
                end else begin
                    e_kind       = smx_pkg::KIND_CHANGE;
                    e_rising     = hit;
                    e_led_valid  = hit && r_job.led_en;
                    e_led_square = e_led_valid ? smx_pkg::LED_LUT[idx] : 4'd0;
                end
            end
            smx_pkg::MODE_QUERY: begin
                e_kind   = smx_pkg::KIND_OCC;
                e_square = smx_pkg::map_square(idx, r_job.rot_new);
            end
            default: begin
                e_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (emit) begin
            r_kind       <= e_kind;
            r_square     <= e_square;
            r_rising     <= e_rising;
            r_led_valid  <= e_led_valid;
            r_led_square <= e_led_square;
            r_row_drive  <= r_job.row_drive;
            r_rot_now    <= r_job.rot_new;
            r_last       <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_mask <= i_job.mask;
            end else if (emit) begin
                r_mask <= rest;
                if (e_last) r_busy <= 1'b0;
            end
            if (emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_square       = r_square;
    assign o_rising       = r_rising;
    assign o_led_valid    = r_led_valid;
    assign o_led_square   = r_led_square;
    assign o_row_drive    = r_row_drive;
    assign o_rotation_now = r_rot_now;
    assign o_last         = r_last;

    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_job.mode != smx_pkg::MODE_EMPTY |-> r_mask != 16'd0)
        else $error("busy job with no squares left");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_last |-> r_busy)
        else $error("non-final beat with no job in progress");

    a_cal_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == smx_pkg::KIND_CAL |-> r_rising && !r_led_valid)
        else $error("calibration beat with wrong flags");

endmodule

/* sv/sensor_matrix_scanner.sv */
// Top level of the 4x4 sensor matrix scanner.
`timescale 1ns / 1ps

// The front end takes one item per cycle while the job queue (QUEUE_DEPTH entries) has room
// and updates the scan state at once; the back end loads a job from the queue and then sends
// one result beat per cycle from its output register while the output is ready, one beat per
// square in the job's mask or a single beat for an item with no event, and loads the next job
// only after the last beat. Config writes are always ready and take effect on the next item.
module sensor_matrix_scanner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_column_levels,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_square,
    output logic        o_rising,
    output logic        o_led_valid,
    output logic [3:0]  o_led_square,
    output logic [2:0]  o_row_drive,
    output logic [1:0]  o_rotation_now,
    output logic        o_last
);

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    smx_pkg::t_job push_job;
    smx_pkg::t_job head_job;

    smx_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_now_ms        (i_now_ms),
        .i_column_levels (i_column_levels),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    smx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_job)
    );

    smx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_job          (head_job),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_square       (o_square),
        .o_rising       (o_rising),
        .o_led_valid    (o_led_valid),
        .o_led_square   (o_led_square),
        .o_row_drive    (o_row_drive),
        .o_rotation_now (o_rotation_now),
        .o_last         (o_last)
    );

endmodule

/* dv/sensor_matrix_scanner_test.sv */
// Self-checking testbench of the 4x4 sensor matrix scanner: directed and random scans.
`timescale 1ns / 1ps

module sensor_matrix_scanner_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         RAND_ITEMS_PER_SETTING = 64;
    localparam int         SETTINGS_RAND = 6;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_ms;
        logic [3:0]  levels;
    } t_scan_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] square;
        logic       rising;
        logic       led_valid;
        logic [3:0] led_square;
        logic [2:0] row_drive;
        logic [1:0] rotation_now;
        logic       last;
    } t_scan_result;

    // LED index per raw square, and raw square per displayed square for rotations 1..3
    localparam logic [3:0] LED_INDEX [0:15] = '{
        4'd0, 4'd7, 4'd8, 4'd15, 4'd1, 4'd6, 4'd9, 4'd14,
        4'd2, 4'd5, 4'd10, 4'd13, 4'd3, 4'd4, 4'd11, 4'd12
    };
    localparam logic [3:0] ROT_RAW [0:2][0:15] = '{
        '{4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
          4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3},
        '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
          4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
        '{4'd3, 4'd7, 4'd11, 4'd15, 4'd2, 4'd6, 4'd10, 4'd14,
          4'd1, 4'd5, 4'd9, 4'd13, 4'd0, 4'd4, 4'd8, 4'd12}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = smx_pkg::OP_TICK;
    logic [31:0] i_now_ms = '0;
    logic [3:0]  i_column_levels = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = smx_pkg::CFG_INTERVAL;
    logic [15:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_square;
    logic        o_rising;
    logic        o_led_valid;
    logic [3:0]  o_led_square;
    logic [2:0]  o_row_drive;
    logic [1:0]  o_rotation_now;
    logic        o_last;

    sensor_matrix_scanner u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_now_ms       (i_now_ms),
        .i_column_levels(i_column_levels),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_square       (o_square),
        .o_rising       (o_rising),
        .o_led_valid    (o_led_valid),
        .o_led_square   (o_led_square),
        .o_row_drive    (o_row_drive),
        .o_rotation_now (o_rotation_now),
        .o_last         (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Scanner shadow state
    logic [15:0] interval_ms = smx_pkg::INTERVAL_RESET;
    logic        led_on = 1'b1;
    logic [31:0] due_ms = '0;
    logic [2:0]  scan_step = 3'd7;
    logic [3:0]  occupied [0:3] = '{4'd0, 4'd0, 4'd0, 4'd0};
    logic [1:0]  rotation = 2'd0;
    logic        calibrating = 1'b0;
    logic [2:0]  drive_row = smx_pkg::ROW_NONE;

    t_scan_item   scan_items [$];
    t_scan_result pending_results [$];
    t_scan_item   next_beat;
    int           items_queued = 0;
    int           items_taken = 0;
    int           ignored_items = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           settings_used = 0;
    bit           no_idle = 1'b0;

    function automatic logic [3:0] shown_square(input logic [3:0] raw, input logic [1:0] rot);
        logic [3:0] sq;
        sq = raw;
        if (rot != 2'd0) begin
            for (int k = 0; k < 16; k++) begin
                if (ROT_RAW[rot - 1][k] == raw) sq = 4'(k);
            end
        end
        return sq;
    endfunction

    function automatic string fmt_result(input t_scan_result r);
        return $sformatf("kind=%0d sq=%0d rise=%0b led=%0b/%0d row=%0d rot=%0d last=%0b",
                         r.kind, r.square, r.rising, r.led_valid, r.led_square,
                         r.row_drive, r.rotation_now, r.last);
    endfunction

    // Advance the shadow state by one item and queue the results it causes
    task automatic predict_scan(input logic [1:0] op, input logic [31:0] now,
                                input logic [3:0] levels);
        t_scan_result evs [$];
        t_scan_result r;
        logic [3:0]   act;
        logic [3:0]   diff;
        logic [1:0]   row;
        logic [3:0]   raw;
        if (op == smx_pkg::OP_TICK) begin
            if (now > due_ms) begin
                scan_step = scan_step + 3'd1;
                due_ms    = now + {16'd0, interval_ms};
                row       = scan_step[2:1];
                if (scan_step[0]) begin
                    drive_row = {1'b0, row};
                end else begin
                    act          = ~levels;
                    diff         = act ^ occupied[row];
                    occupied[row] = act;
                    for (int c = 0; c < smx_pkg::COLS; c++) begin
                        if (diff[c]) begin
                            raw = {row, 2'(c)};
                            r   = '0;
                            if (act[c] && calibrating) begin
                                calibrating = 1'b0;
                                if (raw == 4'd0)  rotation = 2'd0;
                                if (raw == 4'd3)  rotation = 2'd3;
                                if (raw == 4'd12) rotation = 2'd1;
                                if (raw == 4'd15) rotation = 2'd2;
                                r.kind   = smx_pkg::KIND_CAL;
                                r.rising = 1'b1;
                            end else begin
                                r.kind       = smx_pkg::KIND_CHANGE;
                                r.rising     = act[c];
                                r.led_valid  = act[c] && led_on;
                                r.led_square = r.led_valid ? LED_INDEX[raw] : 4'd0;
                            end
                            r.square = shown_square(raw, rotation);
                            evs.push_back(r);
                        end
                    end
                end
            end
        end else if (op == smx_pkg::OP_CAL) begin
            calibrating = 1'b1;
        end else if (op == smx_pkg::OP_QUERY) begin
            for (int rr = 0; rr < smx_pkg::ROWS; rr++) begin
                for (int c = 0; c < smx_pkg::COLS; c++) begin
                    if (occupied[rr][c]) begin
                        r        = '0;
                        r.kind   = smx_pkg::KIND_OCC;
                        r.square = shown_square(4'(rr * smx_pkg::COLS + c), rotation);
                        evs.push_back(r);
                    end
                end
            end
        end
        if (evs.size() == 0) begin
            r      = '0;
            r.kind = smx_pkg::KIND_NONE;
            evs.push_back(r);
        end
        foreach (evs[k]) begin
            evs[k].row_drive    = drive_row;
            evs[k].rotation_now = rotation;
            evs[k].last         = (k == evs.size() - 1);
            pending_results.push_back(evs[k]);
        end
    endtask

    task automatic add_item(input logic [1:0] op, input logic [31:0] now,
                            input logic [3:0] levels);
        t_scan_item it;
        it.op     = op;
        it.now_ms = now;
        it.levels = levels;
        predict_scan(op, now, levels);
        scan_items.push_back(it);
        items_queued++;
        if (op == OP_UNUSED) ignored_items++;
    endtask

    // Tick just past the due time so the scan advances
    task automatic due_tick(input logic [3:0] levels, input int slack);
        logic [31:0] now;
        now = (due_ms > 32'hFFFF_FF00) ? 32'hFFFF_FFFF : due_ms + 32'd1 + 32'(slack);
        add_item(smx_pkg::OP_TICK, now, levels);
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == smx_pkg::CFG_INTERVAL) interval_ms = data;
        else led_on = data[0];
    endtask

    task automatic apply_setting(input logic [15:0] ivl, input logic led);
        wait_idle();
        write_reg(smx_pkg::CFG_INTERVAL, ivl);
        write_reg(smx_pkg::CFG_LED, {15'd0, led});
        settings_used++;
    endtask

    // Mostly well-formed scans with random content, plus queries, calibration and noise
    task automatic random_items(input int count);
        int          made;
        int          pick;
        logic [3:0]  levels;
        logic [3:0]  hold;
        logic [31:0] now;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            hold = ~occupied[2'((scan_step + 3'd1) >> 1)];
            case ($urandom_range(0, 3))
                0:       levels = 4'($urandom);
                1:       levels = hold;
                default: levels = hold ^ (4'd1 << $urandom_range(0, 3));
            endcase
            if (pick < 62) begin
                if ($urandom_range(0, 7) == 0) add_item(smx_pkg::OP_TICK, $urandom, levels);
                else due_tick(levels, $urandom_range(0, 40));
            end else if (pick < 72) begin
                now = $urandom_range(due_ms, 0);
                add_item(smx_pkg::OP_TICK, now, levels);
            end else if (pick < 80) begin
                add_item(smx_pkg::OP_CAL, $urandom, levels);
            end else if (pick < 92) begin
                add_item(smx_pkg::OP_QUERY, $urandom, levels);
            end else if (pick < 96) begin
                add_item(OP_UNUSED, $urandom, levels);
                made--;
            end else begin
                add_item(smx_pkg::OP_TICK, $urandom, 4'($urandom));
            end
            made++;
        end
    endtask

    // Driver: present the next beat once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) items_taken <= items_taken + 1;
            if (!i_in_valid || o_in_ready) begin
                if (scan_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
                    next_beat       = scan_items.pop_front();
                    i_op            <= next_beat.op;
                    i_now_ms        <= next_beat.now_ms;
                    i_column_levels <= next_beat.levels;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 29);
            if (o_out_valid && i_out_ready) begin
                got = '{o_kind, o_square, o_rising, o_led_valid, o_led_square,
                        o_row_drive, o_rotation_now, o_last};
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result: %s", fmt_result(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at result %0d", results_seen);
                            $display("  want %s", fmt_result(want));
                            $display("  got  %s", fmt_result(got));
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(16'd0, 1'b1);
        add_item(smx_pkg::OP_TICK, 32'd0, 4'hF);    // not due: equal to due time
        add_item(OP_UNUSED, 32'hFFFF_FFFF, 4'h0);
        add_item(smx_pkg::OP_QUERY, 32'd0, 4'h0);   // empty board
        due_tick(4'h0, 0);                           // row 0 all rising, LEDs on
        due_tick(4'hF, 0);
        due_tick(4'hF, 0);
        due_tick(4'hF, 0);
        due_tick(4'b0110, 0);
        due_tick(4'hF, 0);
        due_tick(4'b1110, 0);
        due_tick(4'hF, 0);
        add_item(smx_pkg::OP_QUERY, 32'd0, 4'h0);
        add_item(smx_pkg::OP_CAL, 32'd0, 4'h0);
        due_tick(4'hF, 0);                           // falling edges ignore calibration
        due_tick(4'hF, 0);
        due_tick(4'hF, 0);
        due_tick(4'hF, 0);
        due_tick(4'b0110, 0);
        due_tick(4'hF, 0);
        due_tick(4'b0110, 0);                        // corner rise takes the rotation
        add_item(smx_pkg::OP_QUERY, 32'd0, 4'h0);
        add_item(smx_pkg::OP_CAL, 32'd0, 4'h0);
        due_tick(4'hF, 0);
        due_tick(4'b1101, 0);                        // non-corner rise keeps rotation

        apply_setting(16'hFFFF, 1'b0);
        add_item(smx_pkg::OP_TICK, 32'hFFFF_FFF0, 4'h0);  // due time wraps past zero
        add_item(smx_pkg::OP_TICK, 32'h0000_0100, 4'h0);
        add_item(smx_pkg::OP_TICK, 32'hFFFF_FFFF, 4'h0);  // rising with LEDs off
        add_item(smx_pkg::OP_TICK, 32'h0000_FFFF, 4'h0);

        for (int s = 0; s < SETTINGS_RAND; s++) begin
            case (s)
                0:       apply_setting(16'd10, 1'b1);
                1:       apply_setting(16'd0, 1'b0);
                2:       apply_setting(16'hFFFF, 1'b1);
                3:       apply_setting(16'($urandom), 1'($urandom));
                4:       apply_setting(16'd1, 1'b0);
                default: apply_setting(16'($urandom), 1'b1);
            endcase
            no_idle = (s == 2);
            random_items(RAND_ITEMS_PER_SETTING);
        end
        wait_idle();
        no_idle = 1'b0;
        repeat (20) @(posedge i_clk);

        $display("covered %0d items (%0d with the unused op) over %0d register settings",
                 items_queued, ignored_items, settings_used);
        $display("checked %0d result beats, %0d mismatching", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
sv/smx_pkg.sv
sv/smx_front.sv
sv/smx_queue.sv
sv/smx_back.sv
sv/sensor_matrix_scanner.sv
dv/sensor_matrix_scanner_test.sv
